>>> design/dcp_pkg.sv
// dcp_pkg: shared types, widths and codes of the dag critical path unit
// no dependencies
`timescale 1ns / 1ps
package dcp_pkg;

   localparam int DEF_MAX_NODES = 256;
   localparam int DEF_MAX_EDGES = 1024;

   localparam int KIND_W   = 2;
   localparam int NODE_W   = 9;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 24;
   localparam int CFG_W    = 9;

   localparam logic [KIND_W-1:0] KIND_SET_WEIGHT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_EDGE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN        = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0] from;
      logic [NODE_W-1:0] to;
   } edge_type;

   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] path_length;
      logic              reachable;
   } result_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CLEAR,
      S_CNT_RD,
      S_CNT_CHK,
      S_CNT_WR,
      S_SRT_OUT,
      S_SRT_OCHK,
      S_POP,
      S_POP2,
      S_SCN_RD,
      S_SCN_CHK,
      S_SCN_WR,
      S_RLX_INIT,
      S_RLX_RD,
      S_RLX_U,
      S_RLX_C,
      S_RS_RD,
      S_RS_CHK,
      S_RS_WR,
      S_FIN_RD,
      S_FIN
   } seq_state_type;

endpackage

>>> design/dcp_edge_store.sv
// dcp_edge_store: edge list memory with fill count, one write and one read port
// depends on dcp_pkg
`timescale 1ns / 1ps
module dcp_edge_store #(
   parameter int MAX_NODES = dcp_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = dcp_pkg::DEF_MAX_EDGES,
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
   localparam int ECW = $clog2(MAX_EDGES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  dcp_pkg::edge_type          wr_edge,
   input  logic                       clr,
   input  logic [ECW-1:0]             rd_addr,
   output dcp_pkg::edge_type          rd_edge,
   output logic [ECW-1:0]             count
);

   dcp_pkg::edge_type edge_mem_ff [MAX_EDGES];
   dcp_pkg::edge_type rd_edge_ff;
   logic [ECW-1:0]    count_ff, count_in;
   logic              store;

   always_comb begin
      store = wr_en &&
              (wr_edge.from != '0) && (32'(wr_edge.from) <= MAX_NODES) &&
              (wr_edge.to != '0) && (32'(wr_edge.to) <= MAX_NODES) &&
              (32'(count_ff) < MAX_EDGES);
      count_in = count_ff;
      if (clr) begin
         count_in = '0;
      end else if (store) begin
         count_in = count_ff + ECW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         edge_mem_ff[count_ff[EAW-1:0]] <= wr_edge;
      end
      rd_edge_ff <= edge_mem_ff[rd_addr[EAW-1:0]];
   end

   assign rd_edge = rd_edge_ff;
   assign count   = count_ff;

endmodule

>>> design/dcp_alu.sv
// dcp_alu: shared saturating adder and less-than compare for distances
// depends on dcp_pkg
`timescale 1ns / 1ps
module dcp_alu (
   input  logic [dcp_pkg::DIST_W-1:0] a,
   input  logic [dcp_pkg::DIST_W-1:0] b,
   output logic [dcp_pkg::DIST_W-1:0] sum,
   output logic                       a_lt_b
);

   logic [dcp_pkg::DIST_W:0] raw;

   always_comb begin
      raw    = {1'b0, a} + {1'b0, b};
      sum    = raw[dcp_pkg::DIST_W] ? '1 : raw[dcp_pkg::DIST_W-1:0];
      a_lt_b = a < b;
   end

endmodule

>>> design/dcp_seq.sv
// dcp_seq: node memories and the sequencer for load, topological sort and relaxation
// depends on dcp_pkg, dcp_edge_store, dcp_alu
`timescale 1ns / 1ps
module dcp_seq #(
   parameter int MAX_NODES = dcp_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = dcp_pkg::DEF_MAX_EDGES,
   localparam int NW  = $clog2(MAX_NODES),
   localparam int NCW = NW + 1,
   localparam int ECW = $clog2(MAX_EDGES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [NCW-1:0]                n,
   input  logic                          accept,
   output logic                          idle,
   input  logic [dcp_pkg::KIND_W-1:0]    kind,
   input  logic [dcp_pkg::NODE_W-1:0]    node,
   input  logic [dcp_pkg::NODE_W-1:0]    succ_node,
   input  logic [dcp_pkg::WEIGHT_W-1:0]  weight,
   input  logic                          out_busy,
   output dcp_pkg::result_type           result
);

   localparam int DW = dcp_pkg::DIST_W;

   dcp_pkg::seq_state_type state_ff, state_in;
   logic [NCW-1:0] v_ff, v_in, top_ff, top_in, cnt_ff, cnt_in;
   logic [ECW-1:0] e_ff, e_in;
   logic [NW-1:0]  u_ff, u_in, t_ff, t_in;
   logic [DW-1:0]  cand_ff, cand_in;

   // node memories
   logic [ECW-1:0]                indeg_mem_ff  [MAX_NODES];
   logic                          placed_mem_ff [MAX_NODES];
   logic [NW-1:0]                 stack_mem_ff  [MAX_NODES];
   logic [NW-1:0]                 topo_mem_ff   [MAX_NODES];
   logic                          dv_mem_ff     [MAX_NODES];
   logic [DW-1:0]                 dist_mem_ff   [MAX_NODES];
   logic [dcp_pkg::WEIGHT_W-1:0]  weight_mem_ff [MAX_NODES];

   logic [ECW-1:0]                indeg_q_ff;
   logic                          placed_q_ff, dv_q_ff;
   logic [NW-1:0]                 stack_q_ff, topo_q_ff;
   logic [DW-1:0]                 dist_q_ff;
   logic [dcp_pkg::WEIGHT_W-1:0]  weight_q_ff;

   logic [NW-1:0]  nd_ra, nd_wa, stack_ra, stack_wa, stack_wd, topo_ra;
   logic           indeg_we, placed_we, placed_wd, dv_we, dv_wd, dist_we, stack_we;
   logic           topo_we;
   logic [ECW-1:0] indeg_wd;
   logic [DW-1:0]  dist_wd;
   logic           wgt_we;
   logic [NW-1:0]  wgt_wa;

   // edge store
   dcp_pkg::edge_type load_edge, edge_q;
   logic              edge_we, edge_clr;
   logic [ECW-1:0]    edge_cnt;
   logic              usable;
   logic [NW-1:0]     from_idx, to_idx;

   // shared distance unit
   logic [DW-1:0]  alu_b, alu_sum;
   logic           alu_lt;

   assign load_edge.from = node;
   assign load_edge.to   = succ_node;

   dcp_edge_store #(
      .MAX_NODES(MAX_NODES),
      .MAX_EDGES(MAX_EDGES)
   ) u_edges (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (edge_we),
      .wr_edge(load_edge),
      .clr    (edge_clr),
      .rd_addr(e_ff),
      .rd_edge(edge_q),
      .count  (edge_cnt)
   );

   dcp_alu u_alu (
      .a     (dist_q_ff),
      .b     (alu_b),
      .sum   (alu_sum),
      .a_lt_b(alu_lt)
   );

   always_comb begin
      usable = (edge_q.from != '0) && (32'(edge_q.from) <= 32'(n)) &&
               (edge_q.to != '0) && (32'(edge_q.to) <= 32'(n));
      from_idx = NW'(32'(edge_q.from) - 32'd1);
      to_idx   = NW'(32'(edge_q.to) - 32'd1);
   end

   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      e_in      = e_ff;
      top_in    = top_ff;
      cnt_in    = cnt_ff;
      u_in      = u_ff;
      t_in      = t_ff;
      cand_in   = cand_ff;
      idle      = 1'b0;
      nd_ra     = v_ff[NW-1:0];
      nd_wa     = v_ff[NW-1:0];
      stack_ra  = NW'(top_ff - NCW'(1));
      stack_wa  = top_ff[NW-1:0];
      stack_wd  = t_ff;
      stack_we  = 1'b0;
      topo_ra   = v_ff[NW-1:0];
      topo_we   = 1'b0;
      indeg_we  = 1'b0;
      indeg_wd  = '0;
      placed_we = 1'b0;
      placed_wd = 1'b0;
      dv_we     = 1'b0;
      dv_wd     = 1'b0;
      dist_we   = 1'b0;
      dist_wd   = cand_ff;
      wgt_we    = 1'b0;
      wgt_wa    = NW'(32'(node) - 32'd1);
      edge_we   = 1'b0;
      edge_clr  = 1'b0;
      alu_b     = DW'(weight_q_ff);
      result    = '0;

      unique case (state_ff)
         dcp_pkg::S_IDLE: begin
            idle = 1'b1;
            if (accept) begin
               priority if (kind == dcp_pkg::KIND_SET_WEIGHT) begin
                  wgt_we = (node != '0) && (32'(node) <= MAX_NODES);
               end else if (kind == dcp_pkg::KIND_ADD_EDGE) begin
                  edge_we = 1'b1;
               end else if (kind == dcp_pkg::KIND_RUN) begin
                  v_in     = '0;
                  state_in = dcp_pkg::S_CLEAR;
               end else begin
                  // unused kind is dropped
                  state_in = dcp_pkg::S_IDLE;
               end
            end
         end
         dcp_pkg::S_CLEAR: begin
            indeg_we  = 1'b1;
            placed_we = 1'b1;
            dv_we     = 1'b1;
            v_in      = v_ff + NCW'(1);
            if (v_ff == n - NCW'(1)) begin
               e_in     = '0;
               state_in = dcp_pkg::S_CNT_RD;
            end
         end
         dcp_pkg::S_CNT_RD: begin
            if (e_ff == edge_cnt) begin
               v_in     = '0;
               top_in   = '0;
               cnt_in   = '0;
               state_in = dcp_pkg::S_SRT_OUT;
            end else begin
               state_in = dcp_pkg::S_CNT_CHK;
            end
         end
         dcp_pkg::S_CNT_CHK: begin
            nd_ra = to_idx;
            t_in  = to_idx;
            if (usable) begin
               state_in = dcp_pkg::S_CNT_WR;
            end else begin
               e_in     = e_ff + ECW'(1);
               state_in = dcp_pkg::S_CNT_RD;
            end
         end
         dcp_pkg::S_CNT_WR: begin
            nd_wa    = t_ff;
            indeg_we = 1'b1;
            indeg_wd = indeg_q_ff + ECW'(1);
            e_in     = e_ff + ECW'(1);
            state_in = dcp_pkg::S_CNT_RD;
         end
         dcp_pkg::S_SRT_OUT: begin
            if (v_ff == n) begin
               state_in = dcp_pkg::S_RLX_INIT;
            end else begin
               state_in = dcp_pkg::S_SRT_OCHK;
            end
         end
         dcp_pkg::S_SRT_OCHK: begin
            if (indeg_q_ff == '0 && !placed_q_ff) begin
               stack_we = 1'b1;
               stack_wd = v_ff[NW-1:0];
               top_in   = top_ff + NCW'(1);
               state_in = dcp_pkg::S_POP;
            end else begin
               v_in     = v_ff + NCW'(1);
               state_in = dcp_pkg::S_SRT_OUT;
            end
         end
         dcp_pkg::S_POP: begin
            if (top_ff == '0) begin
               v_in     = v_ff + NCW'(1);
               state_in = dcp_pkg::S_SRT_OUT;
            end else begin
               top_in   = top_ff - NCW'(1);
               state_in = dcp_pkg::S_POP2;
            end
         end
         dcp_pkg::S_POP2: begin
            u_in      = stack_q_ff;
            nd_wa     = stack_q_ff;
            placed_we = 1'b1;
            placed_wd = 1'b1;
            topo_we   = 1'b1;
            cnt_in    = cnt_ff + NCW'(1);
            e_in      = '0;
            state_in  = dcp_pkg::S_SCN_RD;
         end
         dcp_pkg::S_SCN_RD: begin
            state_in = (e_ff == edge_cnt) ? dcp_pkg::S_POP : dcp_pkg::S_SCN_CHK;
         end
         dcp_pkg::S_SCN_CHK: begin
            nd_ra = to_idx;
            t_in  = to_idx;
            if (usable && from_idx == u_ff) begin
               state_in = dcp_pkg::S_SCN_WR;
            end else begin
               e_in     = e_ff + ECW'(1);
               state_in = dcp_pkg::S_SCN_RD;
            end
         end
         dcp_pkg::S_SCN_WR: begin
            nd_wa = t_ff;
            if (indeg_q_ff != '0) begin
               indeg_we = 1'b1;
               indeg_wd = indeg_q_ff - ECW'(1);
               if (indeg_q_ff == ECW'(1) && 32'(top_ff) < MAX_NODES) begin
                  stack_we = 1'b1;
                  top_in   = top_ff + NCW'(1);
               end
            end
            e_in     = e_ff + ECW'(1);
            state_in = dcp_pkg::S_SCN_RD;
         end
         dcp_pkg::S_RLX_INIT: begin
            nd_wa    = '0;
            dv_we    = 1'b1;
            dv_wd    = 1'b1;
            dist_we  = 1'b1;
            dist_wd  = '0;
            v_in     = '0;
            state_in = dcp_pkg::S_RLX_RD;
         end
         dcp_pkg::S_RLX_RD: begin
            state_in = (v_ff == cnt_ff) ? dcp_pkg::S_FIN_RD : dcp_pkg::S_RLX_U;
         end
         dcp_pkg::S_RLX_U: begin
            u_in     = topo_q_ff;
            nd_ra    = topo_q_ff;
            state_in = dcp_pkg::S_RLX_C;
         end
         dcp_pkg::S_RLX_C: begin
            if (dv_q_ff) begin
               cand_in  = alu_sum;
               e_in     = '0;
               state_in = dcp_pkg::S_RS_RD;
            end else begin
               v_in     = v_ff + NCW'(1);
               state_in = dcp_pkg::S_RLX_RD;
            end
         end
         dcp_pkg::S_RS_RD: begin
            if (e_ff == edge_cnt) begin
               v_in     = v_ff + NCW'(1);
               state_in = dcp_pkg::S_RLX_RD;
            end else begin
               state_in = dcp_pkg::S_RS_CHK;
            end
         end
         dcp_pkg::S_RS_CHK: begin
            nd_ra = to_idx;
            t_in  = to_idx;
            if (usable && from_idx == u_ff) begin
               state_in = dcp_pkg::S_RS_WR;
            end else begin
               e_in     = e_ff + ECW'(1);
               state_in = dcp_pkg::S_RS_RD;
            end
         end
         dcp_pkg::S_RS_WR: begin
            nd_wa = t_ff;
            alu_b = cand_ff;
            if (!dv_q_ff || alu_lt) begin
               dist_we = 1'b1;
               dv_we   = 1'b1;
               dv_wd   = 1'b1;
            end
            e_in     = e_ff + ECW'(1);
            state_in = dcp_pkg::S_RS_RD;
         end
         dcp_pkg::S_FIN_RD: begin
            nd_ra    = NW'(n - NCW'(1));
            state_in = dcp_pkg::S_FIN;
         end
         dcp_pkg::S_FIN: begin
            // hold the read address so the operands stay put while stalled
            nd_ra = NW'(n - NCW'(1));
            if (!out_busy) begin
               result.valid       = 1'b1;
               result.reachable   = dv_q_ff;
               result.path_length = dv_q_ff ? alu_sum : '0;
               edge_clr           = 1'b1;
               state_in           = dcp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dcp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcp_pkg::S_IDLE;
         v_ff     <= '0;
         e_ff     <= '0;
         top_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         v_ff     <= v_in;
         e_ff     <= e_in;
         top_ff   <= top_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      t_ff    <= t_in;
      cand_ff <= cand_in;
   end

   always_ff @(posedge clock) begin
      if (indeg_we) begin
         indeg_mem_ff[nd_wa] <= indeg_wd;
      end
      if (placed_we) begin
         placed_mem_ff[nd_wa] <= placed_wd;
      end
      if (dv_we) begin
         dv_mem_ff[nd_wa] <= dv_wd;
      end
      if (dist_we) begin
         dist_mem_ff[nd_wa] <= dist_wd;
      end
      if (stack_we) begin
         stack_mem_ff[stack_wa] <= stack_wd;
      end
      if (topo_we) begin
         topo_mem_ff[cnt_ff[NW-1:0]] <= stack_q_ff;
      end
      if (wgt_we) begin
         weight_mem_ff[wgt_wa] <= weight;
      end
      indeg_q_ff  <= indeg_mem_ff[nd_ra];
      placed_q_ff <= placed_mem_ff[nd_ra];
      dv_q_ff     <= dv_mem_ff[nd_ra];
      dist_q_ff   <= dist_mem_ff[nd_ra];
      weight_q_ff <= weight_mem_ff[nd_ra];
      stack_q_ff  <= stack_mem_ff[stack_ra];
      topo_q_ff   <= topo_mem_ff[topo_ra];
   end

endmodule

>>> design/dag_critical_path_unit.sv
// Longest weighted path through a task graph. Weight and edge words are taken
// one per clock while idle. A run word blocks input until its result is moved
// to the output register. Run time grows with the n nodes in use, the E stored
// edges, the c nodes placed by the sort and the r of them reached from node 1,
// plus any result stall. The single read port of the edge store sets this:
// every edge is walked once per placed node in the sort and once per reached
// node in relaxation.
// depends on dcp_pkg, dcp_seq
`timescale 1ns / 1ps
module dag_critical_path_unit #(
   parameter int MAX_NODES = dcp_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = dcp_pkg::DEF_MAX_EDGES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dcp_pkg::KIND_W-1:0]    req_kind,
   input  logic [dcp_pkg::NODE_W-1:0]    req_node,
   input  logic [dcp_pkg::NODE_W-1:0]    req_succ_node,
   input  logic [dcp_pkg::WEIGHT_W-1:0]  req_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dcp_pkg::DIST_W-1:0]    rsp_path_length,
   output logic                          rsp_reachable,
   input  logic                          csr_wr_en,
   input  logic [dcp_pkg::CFG_W-1:0]     csr_wr_data
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int NCW = NW + 1;

   logic [dcp_pkg::CFG_W-1:0]  node_count_ff;
   logic [NCW-1:0]             n;
   logic                       idle;
   dcp_pkg::result_type        result;
   logic                       rsp_valid_ff;
   logic [dcp_pkg::DIST_W-1:0] path_length_ff;
   logic                       reachable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= dcp_pkg::CFG_W'(1);
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // zero acts as one, anything past the node store acts as its size
   always_comb begin
      if (node_count_ff == '0) begin
         n = NCW'(1);
      end else if (32'(node_count_ff) > MAX_NODES) begin
         n = NCW'(MAX_NODES);
      end else begin
         n = NCW'(node_count_ff);
      end
   end

   dcp_seq #(
      .MAX_NODES(MAX_NODES),
      .MAX_EDGES(MAX_EDGES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .n        (n),
      .accept   (req_valid && idle),
      .idle     (idle),
      .kind     (req_kind),
      .node     (req_node),
      .succ_node(req_succ_node),
      .weight   (req_weight),
      .out_busy (rsp_valid_ff && !rsp_ready),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         path_length_ff <= result.path_length;
         reachable_ff   <= result.reachable;
      end
   end

   assign req_ready       = idle;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_path_length = path_length_ff;
   assign rsp_reachable   = reachable_ff;

endmodule

>>> bench/dcp_checker.sv
// dcp_checker: watches the word, result and csr ports of the dag critical path unit,
// predicts each run result and compares it; depends on dcp_pkg
`timescale 1ns / 1ps
module dcp_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [dcp_pkg::KIND_W-1:0]    req_kind,
   input  logic [dcp_pkg::NODE_W-1:0]    req_node,
   input  logic [dcp_pkg::NODE_W-1:0]    req_succ_node,
   input  logic [dcp_pkg::WEIGHT_W-1:0]  req_weight,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [dcp_pkg::DIST_W-1:0]    rsp_path_length,
   input  logic                          rsp_reachable,
   input  logic                          csr_wr_en,
   input  logic [dcp_pkg::CFG_W-1:0]     csr_wr_data,
   output int                            fail_count,
   output int                            pending
);

   localparam int NODES    = dcp_pkg::DEF_MAX_NODES;
   localparam int EDGES    = dcp_pkg::DEF_MAX_EDGES;
   localparam int DW       = dcp_pkg::DIST_W;
   localparam int DIST_SAT = 24'hFFFFFF;

   typedef struct {
      logic [DW-1:0] path_length;
      logic          reachable;
   } path_result_type;

   logic [dcp_pkg::WEIGHT_W-1:0] weight_mem [NODES];
   logic [dcp_pkg::NODE_W-1:0]   arc_src [EDGES];
   logic [dcp_pkg::NODE_W-1:0]   arc_dst [EDGES];
   int                           arc_count;
   logic [dcp_pkg::CFG_W-1:0]    node_cfg;
   path_result_type              path_due_q[$];

   function automatic bit arc_ok(int e, int n);
      return arc_src[e] >= 1 && arc_src[e] <= n && arc_dst[e] >= 1 && arc_dst[e] <= n;
   endfunction

   function automatic int sat_sum(int a, int b);
      return (a + b > DIST_SAT) ? DIST_SAT : a + b;
   endfunction

   // in-degree sort from a stack, then relax longest distances from node 1
   function automatic path_result_type longest_path();
      path_result_type r;
      int n, cnt, sp, u, t, cand;
      int indeg [NODES];
      bit placed [NODES];
      bit known [NODES];
      int path_len [NODES];
      int order [NODES];
      int stk [NODES];
      n = (node_cfg == 0) ? 1 : (node_cfg > NODES) ? NODES : int'(node_cfg);
      cnt = 0;
      sp = 0;
      for (int v = 0; v < n; v++) begin
         indeg[v] = 0;
         placed[v] = 0;
         known[v] = 0;
         path_len[v] = 0;
      end
      for (int e = 0; e < arc_count; e++)
         if (arc_ok(e, n)) indeg[arc_dst[e] - 1]++;
      for (int v = 0; v < n; v++) begin
         if (indeg[v] == 0 && !placed[v]) begin
            stk[sp++] = v;
            while (sp > 0) begin
               u = stk[--sp];
               placed[u] = 1;
               order[cnt++] = u;
               for (int e = 0; e < arc_count; e++) begin
                  if (arc_ok(e, n) && arc_src[e] - 1 == u) begin
                     t = arc_dst[e] - 1;
                     if (indeg[t] > 0) begin
                        indeg[t]--;
                        if (indeg[t] == 0 && sp < NODES) stk[sp++] = t;
                     end
                  end
               end
            end
         end
      end
      known[0] = 1;
      for (int i = 0; i < cnt; i++) begin
         u = order[i];
         if (known[u]) begin
            cand = sat_sum(path_len[u], int'(weight_mem[u]));
            for (int e = 0; e < arc_count; e++) begin
               if (arc_ok(e, n) && arc_src[e] - 1 == u) begin
                  t = arc_dst[e] - 1;
                  if (!known[t] || path_len[t] < cand) begin
                     path_len[t] = cand;
                     known[t] = 1;
                  end
               end
            end
         end
      end
      if (known[n - 1]) begin
         r.path_length = DW'(sat_sum(path_len[n - 1], int'(weight_mem[n - 1])));
         r.reachable = 1'b1;
      end else begin
         r.path_length = '0;
         r.reachable = 1'b0;
      end
      arc_count = 0;
      return r;
   endfunction

   assign pending = path_due_q.size();

   always @(posedge clock) begin
      path_result_type due;
      path_result_type fresh;
      if (reset) begin
         fail_count = 0;
         arc_count = 0;
         node_cfg = 1;
         path_due_q.delete();
      end else begin
         if (csr_wr_en) node_cfg = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (path_due_q.size() == 0) begin
               $display("%0t: result with none expected: length %0d reachable %0b",
                        $time, rsp_path_length, rsp_reachable);
               fail_count++;
            end else begin
               due = path_due_q.pop_front();
               if (rsp_path_length !== due.path_length) begin
                  $display("%0t: path_length expected %0d actual %0d",
                           $time, due.path_length, rsp_path_length);
                  fail_count++;
               end
               if (rsp_reachable !== due.reachable) begin
                  $display("%0t: reachable expected %0b actual %0b",
                           $time, due.reachable, rsp_reachable);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_kind)
               dcp_pkg::KIND_SET_WEIGHT: begin
                  if (req_node >= 1 && req_node <= NODES) weight_mem[req_node - 1] = req_weight;
               end
               dcp_pkg::KIND_ADD_EDGE: begin
                  if (req_node >= 1 && req_node <= NODES && req_succ_node >= 1 &&
                      req_succ_node <= NODES && arc_count < EDGES) begin
                     arc_src[arc_count] = req_node;
                     arc_dst[arc_count] = req_succ_node;
                     arc_count++;
                  end
               end
               dcp_pkg::KIND_RUN: begin
                  fresh = longest_path();
                  path_due_q.insert(path_due_q.size(), fresh);
               end
               default: ;
            endcase
         end
      end
   end

endmodule

>>> bench/tb.sv
// tb: drives graph loads and runs into the dag critical path unit and gives the verdict
// depends on dcp_pkg, dag_critical_path_unit and dcp_checker
`timescale 1ns / 1ps
module tb;

   localparam int STALL_LIMIT = 300000;
   localparam int WORD_TARGET = 850;
   localparam int KW = dcp_pkg::KIND_W;
   localparam int NW = dcp_pkg::NODE_W;
   localparam int WW = dcp_pkg::WEIGHT_W;
   localparam int CW = dcp_pkg::CFG_W;
   localparam logic [KW-1:0] KIND_SPARE = 2'd3;

   logic                        clock = 0;
   logic                        reset = 1;
   logic                        req_valid = 0;
   logic                        req_ready;
   logic [KW-1:0]               req_kind = dcp_pkg::KIND_SET_WEIGHT;
   logic [NW-1:0]               req_node = '0;
   logic [NW-1:0]               req_succ_node = '0;
   logic [WW-1:0]               req_weight = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 0;
   logic [dcp_pkg::DIST_W-1:0]  rsp_path_length;
   logic                        rsp_reachable;
   logic                        csr_wr_en = 0;
   logic [CW-1:0]               csr_wr_data = '0;
   int                          fail_count;
   int                          pending;

   int  send_gap_pct = 0;
   int  drain_stall_pct = 0;
   bit  long_hold_req = 0;
   int  long_hold_left = 0;
   int  words_sent = 0;
   int  quiet_cycles = 0;
   bit  weight_set [1:256];

   always #5 clock = ~clock;

   dag_critical_path_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_node(req_node), .req_succ_node(req_succ_node), .req_weight(req_weight),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_path_length(rsp_path_length), .rsp_reachable(rsp_reachable),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   dcp_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_node(req_node), .req_succ_node(req_succ_node), .req_weight(req_weight),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_path_length(rsp_path_length), .rsp_reachable(rsp_reachable),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   // result side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (long_hold_left > 0) begin
         rsp_ready = 0;
         long_hold_left--;
      end else if (long_hold_req) begin
         long_hold_req = 0;
         long_hold_left = 400;
         rsp_ready = 0;
      end else begin
         rsp_ready = ($urandom_range(99) >= drain_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge; valid is left high on return
   task automatic put_word(logic [KW-1:0] k, int a, int b, int w);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_kind = k;
      req_node = NW'(a);
      req_succ_node = NW'(b);
      req_weight = WW'(w);
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      @(negedge clock);
      words_sent++;
   endtask

   task automatic set_weight(int nd, int w);
      put_word(dcp_pkg::KIND_SET_WEIGHT, nd, $urandom, w);
      if (nd >= 1 && nd <= 256) weight_set[nd] = 1;
   endtask

   task automatic run_graph();
      put_word(dcp_pkg::KIND_RUN, $urandom, $urandom, $urandom);
   endtask

   // wait for every result, let the block settle, then write node_count
   task automatic idle_and_config(int cnt);
      req_valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = CW'(cnt);
      @(negedge clock);
      csr_wr_en = 0;
   endtask

   function automatic int pick_weight();
      case ($urandom_range(7))
         0: return 65535;
         1: return 0;
         default: return $urandom_range(65535);
      endcase
   endfunction

   task automatic load_random_graph(int cnt, int arcs, bit loops);
      int n, a, b;
      n = (cnt == 0) ? 1 : (cnt > 256) ? 256 : cnt;
      idle_and_config(cnt);
      for (int i = 1; i <= n; i++)
         if (!weight_set[i] || $urandom_range(3) == 0) set_weight(i, pick_weight());
      for (int e = 0; e < arcs; e++) begin
         a = $urandom_range(1, n);
         b = $urandom_range(1, n);
         if (!loops && a >= b) begin
            if (n == 1) continue;
            a = $urandom_range(1, n - 1);
            b = $urandom_range(a + 1, n);
         end
         case ($urandom_range(19))
            0: put_word(dcp_pkg::KIND_ADD_EDGE, $urandom_range(1) ? 0 : $urandom, b, $urandom);
            1: put_word(dcp_pkg::KIND_ADD_EDGE, a, $urandom_range(1) ? 0 : $urandom, $urandom);
            2: put_word(KIND_SPARE, $urandom, $urandom, $urandom);
            3: set_weight($urandom_range(1) ? 0 : $urandom_range(257, 511), $urandom);
            default: put_word(dcp_pkg::KIND_ADD_EDGE, a, b, $urandom);
         endcase
      end
      run_graph();
   endtask

   initial begin
      int g, cnt;
      for (int i = 1; i <= 256; i++) weight_set[i] = 0;
      repeat (2) @(negedge clock);
      reset = 0;

      // single node at reset count, then count 0 which acts as one node
      set_weight(1, 16'hFFFF);
      run_graph();
      idle_and_config(0);
      set_weight(1, 0);
      set_weight(0, 16'h1234);
      set_weight(511, 16'hABCD);
      put_word(KIND_SPARE, 9'h1FF, 9'h1FF, 16'hFFFF);
      run_graph();
      // two nodes linked, then three with the last one cut off
      idle_and_config(2);
      set_weight(2, 16'hFFFF);
      put_word(dcp_pkg::KIND_ADD_EDGE, 1, 2, 0);
      put_word(dcp_pkg::KIND_ADD_EDGE, 0, 2, 0);
      put_word(dcp_pkg::KIND_ADD_EDGE, 1, 511, 0);
      run_graph();
      idle_and_config(3);
      set_weight(3, 7);
      put_word(dcp_pkg::KIND_ADD_EDGE, 1, 2, 0);
      run_graph();
      // cycle in front of the last node, edge beyond the node count
      idle_and_config(3);
      put_word(dcp_pkg::KIND_ADD_EDGE, 1, 2, 0);
      put_word(dcp_pkg::KIND_ADD_EDGE, 2, 3, 0);
      put_word(dcp_pkg::KIND_ADD_EDGE, 3, 2, 0);
      put_word(dcp_pkg::KIND_ADD_EDGE, 1, 200, 0);
      run_graph();

      // largest node counts, including values above the maximum
      load_random_graph(256, 20, 0);
      load_random_graph(9'h1FF, 10, 1);
      put_word(dcp_pkg::KIND_ADD_EDGE, 1, 256, 0);
      run_graph();

      g = 0;
      while (words_sent < WORD_TARGET) begin
         case ((g / 8) % 4)
            0: begin send_gap_pct = 0;  drain_stall_pct = 0;  end
            1: begin send_gap_pct = 56; drain_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  drain_stall_pct = 56; end
            default: begin send_gap_pct = 6; drain_stall_pct = 6; end
         endcase
         case ($urandom_range(29))
            0: cnt = 0;
            1: cnt = $urandom_range(200, 511);
            default: cnt = $urandom_range(1, 12);
         endcase
         load_random_graph(cnt, (cnt > 12) ? $urandom_range(0, 20) : $urandom_range(0, 3 * cnt + 2),
                           $urandom_range(4) == 0);
         if (g % 25 == 12) begin
            // hold results off while words keep coming so the input backs up
            long_hold_req = 1;
            for (int i = 0; i < 4; i++) set_weight($urandom_range(1, 12), $urandom);
            run_graph();
            for (int i = 0; i < 4; i++) set_weight($urandom_range(1, 12), $urandom);
         end
         g++;
      end

      req_valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
